// ----- rtl/core/rrqs_pkg.sv -----
// Shared types and constants for the round-robin quantum scheduler.
`default_nettype none
package rrqs_pkg;

	localparam int ID_W           = 22;
	localparam int TIME_W         = 16;
	localparam int QS_W           = 8;
	localparam int VERDICT_W      = 2;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int PDATA_W        = 32;
	localparam int PADDR_W        = 1;

	localparam logic [QS_W-1:0] QUANTUM_RESET = 8'd10;

	localparam logic [VERDICT_W-1:0] VERDICT_RUN    = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_WAIT   = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_REJECT = 2'd2;

	localparam logic [PADDR_W-1:0] REG_QUANTUM = 1'b0;

	// Broadcast control from the scheduler to every queue cell.
	typedef struct packed {
		logic remove;     // close the gap at the matching cell
		logic shift_all;  // pop the head
		logic load_tail;  // write push data at tail_idx
		logic upd_left;   // matching cell takes the request time
	} rrqs_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/rrqs_cell.sv -----
// One wait-queue slot: holds an id and its time, matches and shifts toward the head.
`default_nettype none
module rrqs_cell
	import rrqs_pkg::*;
#(
	parameter int CNT_W = $clog2(QUEUE_DEPTH_DEF + 1),
	parameter int IDX   = 0
) (
	input  wire logic              clk,
	input  wire rrqs_ctrl_t        ctrl,
	input  wire logic [CNT_W-1:0]  count,
	input  wire logic [CNT_W-1:0]  tail_idx,
	input  wire logic [ID_W-1:0]   req_id,
	input  wire logic [TIME_W-1:0] req_left,
	input  wire logic [ID_W-1:0]   push_id,
	input  wire logic [TIME_W-1:0] push_left,
	input  wire logic [ID_W-1:0]   nxt_id,
	input  wire logic [TIME_W-1:0] nxt_left,
	input  wire logic              seen_i,
	output logic                   seen_o,
	output logic [ID_W-1:0]        id_o,
	output logic [TIME_W-1:0]      left_o
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] left_q;
	logic              match_q;
	logic              occupied;
	logic              shift_en;
	logic              load_en;

	assign occupied = (count > IDX_C);
	assign seen_o   = seen_i | match_q;
	assign shift_en = ctrl.shift_all | (ctrl.remove & seen_o);
	assign load_en  = ctrl.load_tail & (tail_idx == IDX_C);
	assign id_o     = id_q;
	assign left_o   = left_q;

	always_ff @(posedge clk) begin
		match_q <= occupied && (id_q == req_id);
		if (load_en) begin
			id_q   <= push_id;
			left_q <= push_left;
		end else if (shift_en) begin
			id_q   <= nxt_id;
			left_q <= nxt_left;
		end else if (ctrl.upd_left && match_q) begin
			left_q <= req_left;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/round_robin_quantum_scheduler_unit.sv -----
// Top level: request control, running-job registers, config port and the queue cell row.
// A request is registered, then compared in the cells; its result is registered at the update.
// A new request is taken only once the previous one is through compare and update in the cells.
// The next request is taken while an earlier result still waits on a stalled output.
// Reset: asynchronous, active low; idle, queue empty, quantum register back to 10.
// Queue slots hold no reset; only slots below the fill count are ever read.
`default_nettype none
module round_robin_quantum_scheduler_unit
	import rrqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [PADDR_W-1:0]   paddr,
	input  wire logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready,
	input  wire logic                 job_valid,
	output logic                      job_stall,
	input  wire logic [ID_W-1:0]      job_id,
	input  wire logic [TIME_W-1:0]    time_left,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic [VERDICT_W-1:0]      verdict,
	output logic                      busy_res,
	output logic [ID_W-1:0]           owner_id,
	output logic [TIME_W-1:0]         owner_time_left
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MATCH = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0]        state_q;
	logic [QS_W-1:0]   quantum_q;
	logic [ID_W-1:0]   req_id_q;
	logic [TIME_W-1:0] req_left_q;
	logic              run_flag_q;
	logic [ID_W-1:0]   run_id_q;
	logic [TIME_W-1:0] run_left_q;
	logic [QS_W-1:0]   slices_q;
	logic [CNT_W-1:0]  count_q;
	logic              res_valid_q;
	logic [VERDICT_W-1:0] verdict_q;
	logic              busy_q;
	logic [ID_W-1:0]   owner_id_q;
	logic [TIME_W-1:0] owner_left_q;

	logic              exec_go;
	rrqs_ctrl_t        ctrl;
	logic [CNT_W-1:0]  tail_idx;
	logic [ID_W-1:0]   push_id;
	logic [TIME_W-1:0] push_left;
	logic              run_flag_d;
	logic [ID_W-1:0]   run_id_d;
	logic [TIME_W-1:0] run_left_d;
	logic [QS_W-1:0]   slices_d;
	logic [CNT_W-1:0]  count_d;
	logic [VERDICT_W-1:0] verdict_d;
	logic [QS_W-1:0]   slices_dec;
	logic              found;
	logic              cfg_wr;

	logic [ID_W-1:0]   cell_id   [QUEUE_DEPTH+1];
	logic [TIME_W-1:0] cell_left [QUEUE_DEPTH+1];
	logic              seen      [QUEUE_DEPTH+1];

	// Config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_QUANTUM);
	assign prdata = (paddr == REG_QUANTUM) ? PDATA_W'(quantum_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_wr) begin
			quantum_q <= pwdata[QS_W-1:0];
		end
	end

	// Handshake
	assign job_stall = (state_q != ST_IDLE);
	assign exec_go   = (state_q == ST_EXEC) && !(res_valid_q && res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) state_q <= ST_MATCH;
				end
				ST_MATCH: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (exec_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (exec_go) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			req_id_q   <= job_id;
			req_left_q <= time_left;
		end
	end

	// Queue cell row
	assign found      = seen[QUEUE_DEPTH];
	assign slices_dec = (slices_q != '0) ? slices_q - QS_W'(1) : '0;

	always_comb begin
		ctrl       = '0;
		tail_idx   = count_q;
		push_id    = req_id_q;
		push_left  = req_left_q;
		run_flag_d = run_flag_q;
		run_id_d   = run_id_q;
		run_left_d = run_left_q;
		slices_d   = slices_q;
		count_d    = count_q;
		verdict_d  = VERDICT_RUN;
		priority if (req_left_q == '0) begin
			if (run_flag_q && req_id_q == run_id_q) begin
				if (count_q == '0) begin
					run_flag_d = 1'b0;
					run_id_d   = '0;
					run_left_d = '0;
					slices_d   = quantum_q;
				end else begin
					run_id_d       = cell_id[0];
					run_left_d     = cell_left[0];
					slices_d       = quantum_q;
					ctrl.shift_all = 1'b1;
					count_d        = count_q - CNT_ONE;
				end
			end else if (found) begin
				ctrl.remove = 1'b1;
				count_d     = count_q - CNT_ONE;
			end
		end else if (!run_flag_q) begin
			run_flag_d = 1'b1;
			run_id_d   = req_id_q;
			run_left_d = req_left_q;
			slices_d   = quantum_q;
		end else if (req_id_q == run_id_q) begin
			run_left_d = req_left_q;
			slices_d   = slices_dec;
			if (slices_dec == '0 && count_q != '0) begin
				// rotate: pop head, push old owner at the tail
				run_id_d       = cell_id[0];
				run_left_d     = cell_left[0];
				slices_d       = quantum_q;
				ctrl.shift_all = 1'b1;
				ctrl.load_tail = 1'b1;
				tail_idx       = count_q - CNT_ONE;
				push_id        = run_id_q;
				push_left      = req_left_q;
			end
		end else if (found) begin
			ctrl.upd_left = 1'b1;
			verdict_d     = VERDICT_WAIT;
		end else if (count_q < DEPTH_C) begin
			ctrl.load_tail = 1'b1;
			count_d        = count_q + CNT_ONE;
			verdict_d      = VERDICT_WAIT;
		end else begin
			verdict_d = VERDICT_REJECT;
		end
		if (!exec_go) ctrl = '0;
	end

	assign seen[0]                = 1'b0;
	assign cell_id[QUEUE_DEPTH]   = '0;
	assign cell_left[QUEUE_DEPTH] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		rrqs_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.tail_idx  (tail_idx),
			.req_id    (req_id_q),
			.req_left  (req_left_q),
			.push_id   (push_id),
			.push_left (push_left),
			.nxt_id    (cell_id[i+1]),
			.nxt_left  (cell_left[i+1]),
			.seen_i    (seen[i]),
			.seen_o    (seen[i+1]),
			.id_o      (cell_id[i]),
			.left_o    (cell_left[i])
		);
	end

	// Owner state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_flag_q <= 1'b0;
			run_id_q   <= '0;
			run_left_q <= '0;
			slices_q   <= QUANTUM_RESET;
			count_q    <= '0;
		end else if (exec_go) begin
			run_flag_q <= run_flag_d;
			run_id_q   <= run_id_d;
			run_left_q <= run_left_d;
			slices_q   <= slices_d;
			count_q    <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			verdict_q    <= verdict_d;
			busy_q       <= run_flag_d;
			owner_id_q   <= run_id_d;
			owner_left_q <= run_left_d;
		end
	end

	assign res_valid       = res_valid_q;
	assign verdict         = verdict_q;
	assign busy_res        = busy_q;
	assign owner_id        = owner_id_q;
	assign owner_time_left = owner_left_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue fill count beyond depth");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!run_flag_q |-> (run_id_q == '0 && run_left_q == '0))
		else $error("idle owner registers not cleared");

	a_accept_to_match: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && !job_stall) |=> (state_q == ST_MATCH))
		else $error("accepted request did not enter compare");

	a_count_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_go |=> $stable(count_q))
		else $error("fill count changed outside update");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> (count_q == $past(count_q) || count_q == $past(count_q) + CNT_ONE
			|| count_q == $past(count_q) - CNT_ONE))
		else $error("fill count moved by more than one");

endmodule
`default_nettype wire
